// File: src/pmwq_pkg.sv
// Package for the priority mutex wait queue.
// Holds queue sizing, operation codes and the transfer, entry and cell control structs.
// No dependencies.
package pmwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W = 16;
	localparam int PRIO_W = 16;
	localparam int WAIT_W = 5;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		op_t operation;
		logic [ID_W-1:0] requester_id;
		logic [PRIO_W-1:0] request_priority;
	} req_t;

	typedef struct packed {
		logic grant_valid;
		logic [ID_W-1:0] grant_id;
		logic request_dropped;
		logic [WAIT_W-1:0] waiting_count;
		logic lock_busy;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef struct packed {
		logic step;
		logic ins_en;
		logic pop;
		logic [PRIO_W-1:0] new_prio;
		logic [ID_W-1:0] new_id;
	} cell_ctrl_t;

endpackage

// File: src/priority_mutex_wait_queue.sv
// Top level of the priority mutex wait queue.
// Instantiates a row of pmwq_cell slots and holds the lock, count and result register.
// Depends on pmwq_pkg and pmwq_cell.

// One lock with up to QUEUE_DEPTH waiters kept in priority order (lower number first,
// arrival order among equals) in a row of slot cells. Each transfer is a request or a
// release and yields exactly one registered result; insertion and the pop of the
// head to the lock both take effect in the cycle of acceptance, since every cell
// compares its own priority with the newcomer and picks its value from itself, its left
// neighbour, the request or, on a pop, its right neighbour. One item is taken per cycle;
// the only hold-off is a stalled result register. A release frees the lock without
// checking the owner, and a request meeting a full queue is dropped and flagged.
module priority_mutex_wait_queue
	import pmwq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	logic lock_q;
	logic [CNT_W-1:0] count_q;
	logic out_valid_q;
	rsp_t out_q;

	logic accept;
	logic full;
	logic acquire;
	logic ins_do;
	logic lock_free;
	logic grant;
	logic lock_d;
	logic [CNT_W-1:0] count_d;
	cell_ctrl_t ctrl;
	rsp_t rsp;

	entry_t cur [QUEUE_DEPTH];
	entry_t ins [QUEUE_DEPTH];
	logic take [QUEUE_DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign acquire = (in_data.operation == OP_ACQUIRE);
	assign ins_do = acquire && !full;
	assign lock_free = !acquire || !lock_q;
	assign grant = lock_free && ins[0].valid;
	assign lock_d = grant || !lock_free;
	assign count_d = count_q + CNT_W'(ins_do) - CNT_W'(grant);

	assign ctrl = '{
		step: accept,
		ins_en: ins_do,
		pop: grant,
		new_prio: in_data.request_priority,
		new_id: in_data.requester_id
	};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic prev_take;
		entry_t prev_entry;
		entry_t next_ins;
		if (i == 0) begin : g_head
			assign prev_take = 1'b0;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_take = take[i-1];
			assign prev_entry = cur[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_ins = '0;
		end else begin : g_inner
			assign next_ins = ins[i+1];
		end
		pmwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_take  (prev_take),
			.prev_entry (prev_entry),
			.next_ins   (next_ins),
			.take       (take[i]),
			.cur        (cur[i]),
			.ins        (ins[i])
		);
	end

	always_comb begin
		rsp.grant_valid = grant;
		rsp.grant_id = grant ? ins[0].id : '0;
		rsp.request_dropped = acquire && full;
		rsp.waiting_count = WAIT_W'(count_d);
		rsp.lock_busy = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			lock_q <= lock_d;
			count_q <= count_d;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("wait count beyond queue depth");

	a_waiters_hold_lock: assert property (@(posedge clk) disable iff (!arst_n)
		cur[0].valid |-> lock_q)
		else $error("waiter queued while lock free");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur[0].valid == (count_q != '0))
		else $error("head slot disagrees with count");

	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && grant |=> out_data.lock_busy && lock_q)
		else $error("grant without lock held");
`endif

endmodule

// File: src/pmwq_cell.sv
// One slot of the sorted wait queue.
// Decides locally between keep, take-from-left and take-new, then shifts left on a pop.
// Depends on pmwq_pkg.
module pmwq_cell
	import pmwq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_take,
	input  entry_t     prev_entry,
	input  entry_t     next_ins,
	output logic       take,
	output entry_t     cur,
	output entry_t     ins
);

	logic valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [ID_W-1:0] id_q;
	entry_t nxt;

	assign cur = '{valid: valid_q, prio: prio_q, id: id_q};
	assign take = !valid_q || (prio_q > ctrl.new_prio);

	always_comb begin
		priority if (!ctrl.ins_en || !take) begin
			ins = cur;
		end else if (prev_take) begin
			ins = prev_entry;
		end else begin
			ins = '{valid: 1'b1, prio: ctrl.new_prio, id: ctrl.new_id};
		end
		nxt = ctrl.pop ? next_ins : ins;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			prio_q <= nxt.prio;
			id_q <= nxt.id;
		end
	end

endmodule
